@@ src/rgbe_scanline_rle_decoder_defines.svh @@
// Assertion macros shared by the RGBE scanline decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RGBE_SCANLINE_RLE_DECODER_DEFINES_SVH
`define RGBE_SCANLINE_RLE_DECODER_DEFINES_SVH

// same-cycle implication
`define RGBE_RLE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RGBE_RLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/rgbe_rle_pkg.sv @@
// Types and constants of the RGBE scanline decoder.
// No dependencies; used by every module of the block.
package rgbe_rle_pkg;

   localparam logic [7:0] RunFlag   = 8'd128;
   localparam logic [7:0] RleMarker = 8'd2;

   // flat header word plus three pixel words must fit without stalling the input
   localparam int QueueDepth = 8;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_FLAT    = 3'd1,
      PH_COUNT   = 3'd2,
      PH_RUNVAL  = 3'd3,
      PH_LITERAL = 3'd4,
      PH_SKIP    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_OVERRUN    = 2'd1,
      ERR_ZERO_COUNT = 2'd2
   } err_type;

   typedef enum logic {
      CSR_LINE_WIDTH = 1'b0,
      CSR_IMAGE_ROWS = 1'b1
   } csr_index_type;

   localparam logic [1:0] LastChannel = 2'd3;

   // one queue entry: a single segment, or a flat line header that expands to four
   typedef struct packed {
      logic        quad;
      logic [1:0]  channel;
      logic [15:0] start_x;
      logic [6:0]  run_count;
      logic [31:0] value;
      err_type     error_code;
      logic        line_done;
      logic        image_done;
   } seg_cmd_type;

endpackage

@@ src/rgbe_rle_front.sv @@
// Front end: takes stream bytes, tracks the scanline state and issues segment words.
// Depends on rgbe_rle_pkg and the assertion macros.
`include "rgbe_scanline_rle_decoder_defines.svh"

module rgbe_rle_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  rgbe_rle_pkg::csr_index_type csr_index,
   input  logic [15:0]                 csr_wdata,
   input  logic                        req_accept,
   input  logic [7:0]                  req_data_byte,
   output logic                        push,
   output rgbe_rle_pkg::seg_cmd_type   push_data
);
   import rgbe_rle_pkg::*;

   logic [15:0] line_width_ff, image_rows_ff;
   phase_type   phase_ff, phase_in;
   logic [23:0] held_header_ff, held_header_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [1:0]  channel_ff, channel_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  literal_left_ff, literal_left_in;
   logic [6:0]  pending_run_ff, pending_run_in;
   logic [15:0] rows_done_ff, rows_done_in;

   logic [15:0] w_eff, rows_eff, room;
   logic [16:0] pos_inc, pos_after_run, rows_inc;
   logic [6:0]  run_cnt;
   logic        run_clipped, last_row, rle_header;
   logic [7:0]  lit_dec;
   logic [31:0] hdr;
   logic        finish, end_ch, skip_after;

   assign w_eff         = (line_width_ff == 16'd0) ? 16'd1 : line_width_ff;
   assign rows_eff      = (image_rows_ff == 16'd0) ? 16'd1 : image_rows_ff;
   assign pos_inc       = {1'b0, pos_ff} + 17'd1;
   assign room          = (w_eff > pos_ff) ? (w_eff - pos_ff) : 16'd1;
   assign run_clipped   = {9'd0, pending_run_ff} > room;
   assign run_cnt       = run_clipped ? room[6:0] : pending_run_ff;
   assign pos_after_run = {1'b0, pos_ff} + {10'd0, run_cnt};
   assign lit_dec       = literal_left_ff - 8'd1;
   assign rows_inc      = {1'b0, rows_done_ff} + 17'd1;
   assign last_row      = rows_inc >= {1'b0, rows_eff};
   assign hdr           = {held_header_ff, req_data_byte};
   assign rle_header    = (hdr[31:24] == RleMarker) && (hdr[23:16] == RleMarker) &&
                          (hdr[15:0] == w_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= 16'd1;
         image_rows_ff <= 16'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata;
            CSR_IMAGE_ROWS: image_rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         held_header_ff  <= '0;
         header_count_ff <= '0;
         channel_ff      <= '0;
         pos_ff          <= '0;
         literal_left_ff <= '0;
         pending_run_ff  <= '0;
         rows_done_ff    <= '0;
      end else begin
         phase_ff        <= phase_in;
         held_header_ff  <= held_header_in;
         header_count_ff <= header_count_in;
         channel_ff      <= channel_in;
         pos_ff          <= pos_in;
         literal_left_ff <= literal_left_in;
         pending_run_ff  <= pending_run_in;
         rows_done_ff    <= rows_done_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      held_header_in  = held_header_ff;
      header_count_in = header_count_ff;
      channel_in      = channel_ff;
      pos_in          = pos_ff;
      literal_left_in = literal_left_ff;
      pending_run_in  = pending_run_ff;
      rows_done_in    = rows_done_ff;
      push            = 1'b0;
      push_data       = '0;
      finish          = 1'b0;
      end_ch          = 1'b0;
      skip_after      = 1'b0;
      if (req_accept) begin
         case (phase_ff)
            PH_FLAT: begin
               push                = 1'b1;
               push_data.channel   = channel_ff;
               push_data.start_x   = pos_ff;
               push_data.run_count = 7'd1;
               push_data.value     = {24'd0, req_data_byte};
               if (channel_ff == LastChannel) begin
                  channel_in = '0;
                  pos_in     = pos_inc[15:0];
                  finish     = pos_inc >= {1'b0, w_eff};
               end else begin
                  channel_in = channel_ff + 2'd1;
               end
            end
            PH_COUNT: begin
               if (req_data_byte > RunFlag) begin
                  pending_run_in = req_data_byte[6:0];
                  phase_in       = PH_RUNVAL;
               end else if (req_data_byte == 8'd0) begin
                  push                 = 1'b1;
                  push_data.channel    = channel_ff;
                  push_data.start_x    = pos_ff;
                  push_data.error_code = ERR_ZERO_COUNT;
               end else begin
                  literal_left_in = req_data_byte;
                  phase_in        = PH_LITERAL;
               end
            end
            PH_RUNVAL: begin
               push                 = 1'b1;
               push_data.channel    = channel_ff;
               push_data.start_x    = pos_ff;
               push_data.run_count  = run_cnt;
               push_data.value      = {24'd0, req_data_byte};
               push_data.error_code = run_clipped ? ERR_OVERRUN : ERR_NONE;
               pending_run_in       = '0;
               pos_in               = pos_after_run[15:0];
               if (pos_after_run >= {1'b0, w_eff}) begin
                  end_ch = 1'b1;
               end else begin
                  phase_in = PH_COUNT;
               end
            end
            PH_LITERAL: begin
               push                = 1'b1;
               push_data.channel   = channel_ff;
               push_data.start_x   = pos_ff;
               push_data.run_count = 7'd1;
               push_data.value     = {24'd0, req_data_byte};
               literal_left_in     = lit_dec;
               pos_in              = pos_inc[15:0];
               if (pos_inc >= {1'b0, w_eff}) begin
                  // the byte that fills the line; any rest is dropped later
                  push_data.error_code = (lit_dec != 8'd0) ? ERR_OVERRUN : ERR_NONE;
                  end_ch               = 1'b1;
                  skip_after           = lit_dec != 8'd0;
               end else if (lit_dec == 8'd0) begin
                  phase_in = PH_COUNT;
               end
            end
            PH_SKIP: begin
               literal_left_in = lit_dec;
               if (lit_dec == 8'd0) begin
                  phase_in = (channel_ff == 2'd0) ? PH_HEADER : PH_COUNT;
               end
            end
            default: begin
               held_header_in = hdr[23:0];
               if (header_count_ff != LastChannel) begin
                  header_count_in = header_count_ff + 2'd1;
                  phase_in        = PH_HEADER;
               end else begin
                  header_count_in = '0;
                  channel_in      = '0;
                  pos_in          = '0;
                  if (rle_header) begin
                     phase_in = PH_COUNT;
                  end else begin
                     // flat line: header bytes are the first pixel
                     push                = 1'b1;
                     push_data.quad      = 1'b1;
                     push_data.run_count = 7'd1;
                     push_data.value     = hdr;
                     pos_in              = 16'd1;
                     phase_in            = PH_FLAT;
                     finish              = w_eff == 16'd1;
                  end
               end
            end
         endcase
         if (end_ch) begin
            if (channel_ff == LastChannel) begin
               finish = 1'b1;
            end else begin
               channel_in = channel_ff + 2'd1;
               pos_in     = '0;
               phase_in   = PH_COUNT;
            end
         end
         if (finish) begin
            push_data.line_done  = 1'b1;
            push_data.image_done = last_row;
            rows_done_in         = last_row ? 16'd0 : rows_inc[15:0];
            phase_in             = PH_HEADER;
            header_count_in      = '0;
            channel_in           = '0;
            pos_in               = '0;
         end
         if (skip_after) begin
            phase_in = PH_SKIP;
         end
      end
   end

   `RGBE_RLE_ASSERT_IMPLY(a_skip_has_bytes, clock, reset, phase_ff == PH_SKIP,
      literal_left_ff != 8'd0, "skip phase with no bytes left")
   `RGBE_RLE_ASSERT_IMPLY(a_hdr_count_in_header, clock, reset, header_count_ff != 2'd0,
      phase_ff == PH_HEADER, "partial line header outside header phase")

endmodule

@@ src/rgbe_rle_queue.sv @@
// Short word queue between the front end and the segment emitter.
// Depends on rgbe_rle_pkg and the assertion macros.
`include "rgbe_scanline_rle_decoder_defines.svh"

module rgbe_rle_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rgbe_rle_pkg::seg_cmd_type push_data,
   input  logic                      pop,
   output rgbe_rle_pkg::seg_cmd_type head,
   output logic                      full,
   output logic                      empty
);
   import rgbe_rle_pkg::*;

   seg_cmd_type          entries_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0] count_ff, count_in;

   assign full  = count_ff == QueueCntW'(QueueDepth);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RGBE_RLE_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full || pop,
      "segment queue overflow")

endmodule

@@ src/rgbe_rle_back.sv @@
// Back end: expands queued words into segments and holds the output register.
// Depends on rgbe_rle_pkg and the assertion macros.
`include "rgbe_scanline_rle_decoder_defines.svh"

module rgbe_rle_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rgbe_rle_pkg::seg_cmd_type head,
   input  logic                      empty,
   output logic                      pop,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_channel,
   output logic [15:0]               rsp_start_x,
   output logic [6:0]                rsp_run_count,
   output logic [7:0]                rsp_value,
   output logic                      rsp_line_done,
   output logic                      rsp_image_done,
   output logic [1:0]                rsp_error_code
);
   import rgbe_rle_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  sub_ff, sub_in;
   logic [1:0]  channel_ff, channel_in;
   logic [15:0] start_x_ff, start_x_in;
   logic [6:0]  run_count_ff, run_count_in;
   logic [7:0]  value_ff, value_in;
   logic        line_done_ff, line_done_in;
   logic        image_done_ff, image_done_in;
   err_type     error_ff, error_in;
   logic        load;
   logic [7:0]  quad_byte;

   assign load = !empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      case (sub_ff)
         2'd0:    quad_byte = head.value[31:24];
         2'd1:    quad_byte = head.value[23:16];
         2'd2:    quad_byte = head.value[15:8];
         default: quad_byte = head.value[7:0];
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      sub_in        = sub_ff;
      pop           = 1'b0;
      channel_in    = channel_ff;
      start_x_in    = start_x_ff;
      run_count_in  = run_count_ff;
      value_in      = value_ff;
      line_done_in  = line_done_ff;
      image_done_in = image_done_ff;
      error_in      = error_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (head.quad) begin
            // flat header: one pixel per channel at x = 0, done flags on the last
            channel_in    = sub_ff;
            start_x_in    = '0;
            run_count_in  = 7'd1;
            value_in      = quad_byte;
            error_in      = ERR_NONE;
            line_done_in  = head.line_done && (sub_ff == LastChannel);
            image_done_in = head.image_done && (sub_ff == LastChannel);
            pop           = sub_ff == LastChannel;
            sub_in        = sub_ff + 2'd1;
         end else begin
            channel_in    = head.channel;
            start_x_in    = head.start_x;
            run_count_in  = head.run_count;
            value_in      = head.value[7:0];
            error_in      = head.error_code;
            line_done_in  = head.line_done;
            image_done_in = head.image_done;
            pop           = 1'b1;
            sub_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sub_ff       <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      channel_ff    <= channel_in;
      start_x_ff    <= start_x_in;
      run_count_ff  <= run_count_in;
      value_ff      <= value_in;
      line_done_ff  <= line_done_in;
      image_done_ff <= image_done_in;
      error_ff      <= error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_channel    = channel_ff;
   assign rsp_start_x    = start_x_ff;
   assign rsp_run_count  = run_count_ff;
   assign rsp_value      = value_ff;
   assign rsp_line_done  = line_done_ff;
   assign rsp_image_done = image_done_ff;
   assign rsp_error_code = error_ff;

   `RGBE_RLE_ASSERT_IMPLY(a_quad_needs_head, clock, reset, sub_ff != 2'd0, !empty,
      "flat header expansion lost its queue entry")
   `RGBE_RLE_ASSERT_IMPLY(a_image_ends_line, clock, reset, rsp_valid_ff && image_done_ff,
      line_done_ff, "image end without line end")

endmodule

@@ src/rgbe_scanline_rle_decoder.sv @@
// With the queue empty, a byte that makes a segment is written into the queue, then loaded into the rsp_valid register.
// Throughput: one byte per cycle while req_stall is low; each queue word leaves at one segment per cycle
// while rsp_stall allows, a flat line header word as four segments, drained by the eight-entry queue.
// req_stall rises only while the queue is full.
// Reset: synchronous, clears all line state and the queue; line_width and image_rows go to 1.
module rgbe_scanline_rle_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_channel,
   output logic [15:0]                 rsp_start_x,
   output logic [6:0]                  rsp_run_count,
   output logic [7:0]                  rsp_value,
   output logic                        rsp_line_done,
   output logic                        rsp_image_done,
   output logic [1:0]                  rsp_error_code,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  rgbe_rle_pkg::csr_index_type csr_index,
   input  logic [15:0]                 csr_wdata
);
   import rgbe_rle_pkg::*;

   seg_cmd_type push_data, head;
   logic        push, pop, full, empty;
   logic        req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = full;
   assign req_accept = req_valid && !req_stall;

   rgbe_rle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_accept    (req_accept),
      .req_data_byte (req_data_byte),
      .push          (push),
      .push_data     (push_data)
   );

   rgbe_rle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   rgbe_rle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_channel    (rsp_channel),
      .rsp_start_x    (rsp_start_x),
      .rsp_run_count  (rsp_run_count),
      .rsp_value      (rsp_value),
      .rsp_line_done  (rsp_line_done),
      .rsp_image_done (rsp_image_done),
      .rsp_error_code (rsp_error_code)
   );

endmodule

@@ verif/rgbe_scanline_rle_decoder_tb.sv @@
// Self-checking testbench for the RGBE scanline decoder: drives the pixel byte stream,
// register writes and receiver stalls, and checks every decoded segment in order.
// Depends on rgbe_rle_pkg and the rgbe_scanline_rle_decoder RTL.
module rgbe_scanline_rle_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rgbe_rle_pkg::*;

   localparam int unsigned StuckLimit = 5000;
   localparam int unsigned PhaseBytes = 8;

   typedef struct packed {
      logic [1:0]  channel;
      logic [15:0] start_x;
      logic [6:0]  run_count;
      logic [7:0]  value;
      logic        line_done;
      logic        image_done;
      err_type     error_code;
   } segment_type;

   // Decodes the accepted bytes on its own and checks the segments the block emits.
   class rgbe_segment_checker;
      int unsigned line_width;
      int unsigned image_rows;
      phase_type   phase;
      logic [31:0] held_header;
      int unsigned header_count;
      int unsigned channel;
      int unsigned position;
      int unsigned literal_left;
      int unsigned pending_run;
      int unsigned rows_done;
      segment_type segments_due[$];
      int unsigned mismatches;
      int unsigned bytes_taken;
      int unsigned segs_checked;
      int unsigned lines_seen;
      int unsigned images_seen;

      function new();
         line_width   = 1;
         image_rows   = 1;
         phase        = PH_HEADER;
         held_header  = '0;
         header_count = 0;
         channel      = 0;
         position     = 0;
         literal_left = 0;
         pending_run  = 0;
         rows_done    = 0;
         mismatches   = 0;
         bytes_taken  = 0;
         segs_checked = 0;
         lines_seen   = 0;
         images_seen  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] v);
         if (idx == CSR_LINE_WIDTH) begin
            line_width = 32'(v);
         end else begin
            image_rows = 32'(v);
         end
      endfunction

      function int unsigned pending();
         return segments_due.size();
      endfunction

      function void add_segment(int unsigned ch, int unsigned x, int unsigned cnt,
                                logic [7:0] v, err_type e);
         segment_type s;
         s.channel    = ch[1:0];
         s.start_x    = x[15:0];
         s.run_count  = cnt[6:0];
         s.value      = v;
         s.line_done  = 1'b0;
         s.image_done = 1'b0;
         s.error_code = e;
         segments_due.push_back(s);
      endfunction

      // flags the newest segment as the end of a scanline
      function void close_line();
         segment_type s;
         int unsigned rows_eff;
         rows_eff = (image_rows == 0) ? 1 : image_rows;
         s = segments_due.pop_back();
         s.line_done = 1'b1;
         if (rows_done + 1 >= rows_eff) begin
            s.image_done = 1'b1;
            rows_done    = 0;
         end else begin
            rows_done = (rows_done + 1) & 16'hFFFF;
         end
         segments_due.push_back(s);
         phase        = PH_HEADER;
         header_count = 0;
         channel      = 0;
         position     = 0;
      endfunction

      function void end_channel();
         if (channel >= 3) begin
            close_line();
         end else begin
            channel++;
            position = 0;
            phase    = PH_COUNT;
         end
      endfunction

      function void decode_byte(logic [7:0] b);
         int unsigned w;
         int unsigned cnt;
         int unsigned room;
         int unsigned x;
         int unsigned rest;
         err_type     e;
         w = (line_width == 0) ? 1 : line_width;
         bytes_taken++;
         case (phase)
            PH_FLAT: begin
               add_segment(channel, position, 1, b, ERR_NONE);
               if (channel >= 3) begin
                  channel = 0;
                  position++;
                  if (position >= w) close_line();
               end else begin
                  channel++;
               end
            end
            PH_COUNT: begin
               if (b > RunFlag) begin
                  pending_run = 32'(b - RunFlag);
                  phase       = PH_RUNVAL;
               end else if (b == 8'd0) begin
                  add_segment(channel, position, 0, 8'd0, ERR_ZERO_COUNT);
               end else begin
                  literal_left = 32'(b);
                  phase        = PH_LITERAL;
               end
            end
            PH_RUNVAL: begin
               cnt  = pending_run;
               e    = ERR_NONE;
               room = (w > position) ? w - position : 1;
               if (cnt > room) begin
                  cnt = room;
                  e   = ERR_OVERRUN;
               end
               add_segment(channel, position, cnt, b, e);
               pending_run = 0;
               position += cnt;
               if (position >= w) begin
                  end_channel();
               end else begin
                  phase = PH_COUNT;
               end
            end
            PH_LITERAL: begin
               x            = position;
               literal_left = (literal_left - 1) & 8'hFF;
               position++;
               if (position >= w) begin
                  rest = literal_left;
                  add_segment(channel, x, 1, b, (rest > 0) ? ERR_OVERRUN : ERR_NONE);
                  end_channel();
                  // bytes past the line end are swallowed
                  if (rest > 0) phase = PH_SKIP;
               end else begin
                  add_segment(channel, x, 1, b, ERR_NONE);
                  if (literal_left == 0) phase = PH_COUNT;
               end
            end
            PH_SKIP: begin
               literal_left = (literal_left - 1) & 8'hFF;
               if (literal_left == 0) phase = (channel == 0) ? PH_HEADER : PH_COUNT;
            end
            default: begin
               held_header = {held_header[23:0], b};
               if (header_count < 3) begin
                  header_count++;
               end else begin
                  header_count = 0;
                  channel      = 0;
                  position     = 0;
                  if (held_header[31:24] == RleMarker && held_header[23:16] == RleMarker &&
                      held_header[15:0] == w) begin
                     phase = PH_COUNT;
                  end else begin
                     // not an rle header: the four bytes are the first flat pixel
                     for (int i = 0; i < 4; i++)
                        add_segment(i, 0, 1, held_header[31 - 8 * i -: 8], ERR_NONE);
                     position = 1;
                     phase    = PH_FLAT;
                     if (position >= w) close_line();
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_segment(segment_type got);
         segment_type want;
         segs_checked++;
         if (got.line_done) lines_seen++;
         if (got.image_done) images_seen++;
         if (segments_due.size() == 0) begin
            $display("%0t: segment with none expected, expected nothing, %s %0d x %0d n %0d v %0d",
                     $time, "actual ch", got.channel, got.start_x, got.run_count, got.value);
            mismatches++;
            return;
         end
         want = segments_due.pop_front();
         compare_field("channel", want.channel, got.channel);
         compare_field("start_x", want.start_x, got.start_x);
         compare_field("run_count", want.run_count, got.run_count);
         compare_field("value", want.value, got.value);
         compare_field("line_done", want.line_done, got.line_done);
         compare_field("image_done", want.image_done, got.image_done);
         compare_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_data_byte = 8'd0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [1:0]    rsp_channel;
   logic [15:0]   rsp_start_x;
   logic [6:0]    rsp_run_count;
   logic [7:0]    rsp_value;
   logic          rsp_line_done;
   logic          rsp_image_done;
   logic [1:0]    rsp_error_code;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_LINE_WIDTH;
   logic [15:0]   csr_wdata = 16'd0;

   rgbe_segment_checker sb = new();
   segment_type seen_seg;
   logic [7:0]  stream_q[$];
   int unsigned send_idle_pct = 34;
   int unsigned recv_idle_pct = 88;
   int unsigned stuck_cycles = 0;
   int unsigned settings_used = 1;

   rgbe_scanline_rle_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_channel    (rsp_channel),
      .rsp_start_x    (rsp_start_x),
      .rsp_run_count  (rsp_run_count),
      .rsp_value      (rsp_value),
      .rsp_line_done  (rsp_line_done),
      .rsp_image_done (rsp_image_done),
      .rsp_error_code (rsp_error_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // every handshake is observed here, at the edge where it completes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.decode_byte(req_data_byte);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (rsp_valid && !rsp_stall) begin
            seen_seg.channel    = rsp_channel;
            seen_seg.start_x    = rsp_start_x;
            seen_seg.run_count  = rsp_run_count;
            seen_seg.value      = rsp_value;
            seen_seg.line_done  = rsp_line_done;
            seen_seg.image_done = rsp_image_done;
            seen_seg.error_code = err_type'(rsp_error_code);
            sb.check_segment(seen_seg);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= StuckLimit);
      $display("%0t: no handshake for %0d cycles, %0d segments still due",
               $time, StuckLimit, sb.pending());
      $display("FAILURE");
      $finish;
   end

   function automatic logic [7:0] rand_value();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one run-length coded line; a cap cuts long lines short mid-channel
   function automatic void add_rle_line(int unsigned w, int unsigned cap);
      int unsigned pos;
      int unsigned room;
      int unsigned len;
      int unsigned kind;
      stream_q.push_back(RleMarker);
      stream_q.push_back(RleMarker);
      stream_q.push_back(w[15:8]);
      stream_q.push_back(w[7:0]);
      for (int ch = 0; ch < 4; ch++) begin
         pos = 0;
         while (pos < w && stream_q.size() < cap) begin
            room = w - pos;
            kind = $urandom_range(99);
            if (kind < 5) begin
               stream_q.push_back(8'd0);
            end else if (kind < 50) begin
               if (kind < 9) begin
                  len = $urandom_range(127, 1);
               end else begin
                  len = $urandom_range((room < 127) ? room : 127, 1);
               end
               stream_q.push_back(8'(RunFlag + len));
               stream_q.push_back(rand_value());
               pos += (len < room) ? len : room;
            end else begin
               if (kind > 96) begin
                  len = ($urandom_range(3) == 0) ? 128 : room + $urandom_range(3, 1);
                  if (len > 128) len = 128;
               end else begin
                  len = $urandom_range((room < 128) ? room : 128, 1);
               end
               stream_q.push_back(8'(len));
               repeat (len) stream_q.push_back(rand_value());
               pos += (len < room) ? len : room;
            end
         end
      end
   endfunction

   function automatic void add_flat_line(int unsigned w);
      logic [15:0] wrong_w;
      logic [7:0]  first;
      wrong_w = 16'(w + 1);
      if ($urandom_range(3) == 0) begin
         // looks like an rle header but the width does not match
         stream_q.push_back(RleMarker);
         stream_q.push_back(RleMarker);
         stream_q.push_back(wrong_w[15:8]);
         stream_q.push_back(wrong_w[7:0]);
      end else begin
         first = rand_value();
         stream_q.push_back((first == RleMarker) ? 8'd3 : first);
         repeat (3) stream_q.push_back(rand_value());
      end
      repeat (4 * w - 4) stream_q.push_back(rand_value());
   endfunction

   task automatic send_stream();
      logic [7:0] b;
      while (stream_q.size() > 0) begin
         b = stream_q.pop_front();
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= b;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;
   endtask

   task automatic settle();
      do @(posedge clock); while (sb.pending() != 0);
      // a byte that makes no segment may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic write_settings(logic [15:0] w, logic [15:0] r);
      csr_valid <= 1'b1;
      csr_index <= CSR_LINE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_IMAGE_ROWS;
      csr_wdata <= r;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int unsigned w_set;
      int unsigned r_set;
      int unsigned weff;
      int unsigned kind;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // width 1, one row: flat line, rle line with zero count, clipped run,
      // literal overrun with skipped bytes, then an rle header with the wrong width
      stream_q = '{8'hFF, 8'h00, 8'hAA, 8'h55,
                   8'h02, 8'h02, 8'h00, 8'h01,
                   8'h00, 8'h81, 8'h00,
                   8'hFF, 8'hFF,
                   8'h01, 8'h7F,
                   8'h03, 8'h80, 8'h01, 8'hFE,
                   8'h02, 8'h02, 8'h00, 8'h02};
      send_stream();
      settle();

      for (int p = 0; p < 9; p++) begin
         if (p == 3) begin
            send_idle_pct = 88;
            recv_idle_pct = 34;
         end
         if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // widest settings leave a line unfinished, so the next write lowers it mid-line
         case (p)
            0:       begin w_set = 3;     r_set = 2;     end
            1:       begin w_set = 65535; r_set = 65535; end
            2:       begin w_set = 5;     r_set = 1;     end
            3:       begin w_set = 0;     r_set = 0;     end
            4:       begin w_set = 2;     r_set = 65535; end
            5:       begin w_set = 1;     r_set = 1;     end
            6:       begin w_set = 6;     r_set = 3;     end
            7:       begin w_set = 4;     r_set = 2;     end
            default: begin w_set = 65535; r_set = 1;     end
         endcase
         write_settings(16'(w_set), 16'(r_set));
         weff = (w_set == 0) ? 1 : w_set;
         while (stream_q.size() < PhaseBytes) begin
            kind = $urandom_range(99);
            if (kind < 72 || (weff > 8 && kind < 90)) begin
               add_rle_line(weff, (weff > 64) ? PhaseBytes : 32'hFFFF);
            end else if (kind < 90) begin
               add_flat_line(weff);
            end else begin
               repeat ($urandom_range(6, 1)) stream_q.push_back(rand_value());
            end
         end
         send_stream();
         settle();
      end

      $display("Fed %0d stream bytes under %0d register settings: flat and rle lines,",
               sb.bytes_taken, settings_used);
      $display("runs, literals, overruns, zero counts, width and row changes;");
      $display("%0d segments, %0d lines, %0d images",
               sb.segs_checked, sb.lines_seen, sb.images_seen);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
